FILE: hw/rtl/htbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared widths and codes for the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

  localparam int IDX_W  = 9;  // node index fields and root register
  localparam int SYM_W  = 8;  // symbol byte on the ports
  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_BIT     = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  // Root entry refresh after a root register write
  typedef enum logic [1:0] {
    RF_IDLE,
    RF_READ,
    RF_WAIT
  } rf_state_t;

endpackage

FILE: hw/rtl/htbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/htbd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_fifo
// Small register FIFO for decoded symbols; exposes its fill count.
// ----------------------------------------------------------------------------
module htbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [WIDTH-1:0]           out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/huffman_tree_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Bit-serial Huffman decoder walking a node table held in RAM.
// ----------------------------------------------------------------------------
// Channel  Signals                                   Carries
// cfg      cfg_valid/cfg_ready, root_index           root node index
// in       in_valid/in_ready, mode, node_index,      node write, code bit,
//          node_is_leaf, node_symbol, left_child,    or walk restart
//          right_child, code_bit
// out      out_valid/out_ready, symbol               decoded symbol
//
// One request per cycle while in_ready is high. The current node entry is cached
// in flops; a code bit on an internal node reads the child entry from the table
// RAM and resolves it in the next cycle, overlapping the next request. A symbol
// passes the pending read or emit flag, then the output FIFO, before out offers it.
// A root write reloads the cached root entry in RF_READ and RF_WAIT; in is held off.
// No clearing pass after reset; in stalls when the output FIFO could overflow.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [htbd_pkg::IDX_W-1:0]  root_index,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [htbd_pkg::MODE_W-1:0] mode,
  input  logic [htbd_pkg::IDX_W-1:0]  node_index,
  input  logic                        node_is_leaf,
  input  logic [htbd_pkg::SYM_W-1:0]  node_symbol,
  input  logic [htbd_pkg::IDX_W-1:0]  left_child,
  input  logic [htbd_pkg::IDX_W-1:0]  right_child,
  input  logic                        code_bit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [htbd_pkg::SYM_W-1:0]  symbol
);

  localparam int AW        = $clog2(NODE_COUNT);
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic                          leaf;
    logic [SYMBOL_BITS-1:0]        sym;
    logic [htbd_pkg::IDX_W-1:0]    left;
    logic [htbd_pkg::IDX_W-1:0]    right;
  } node_t;

  localparam int ENTRY_W = $bits(node_t);

  function automatic logic in_range(logic [htbd_pkg::IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  // Registers
  logic [htbd_pkg::IDX_W-1:0] root;
  logic [htbd_pkg::IDX_W-1:0] walk;
  node_t                      root_entry;
  node_t                      cur_entry;
  logic                       p_read;      // child read in flight
  logic                       p_oob;       // that child is out of table range
  logic                       p_emit;      // known symbol to emit
  logic [SYMBOL_BITS-1:0]     p_sym;
  logic                       rf_oob;
  htbd_pkg::rf_state_t        rf_state;

  logic [htbd_pkg::IDX_W-1:0] walk_next;
  node_t                      root_entry_next;
  node_t                      cur_entry_next;
  logic                       p_read_next;
  logic                       p_oob_next;
  logic                       p_emit_next;
  logic [SYMBOL_BITS-1:0]     p_sym_next;
  htbd_pkg::rf_state_t        rf_state_next;

  // RAM side
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  node_t                rd_entry;
  node_t                wr_entry;

  // Resolved walk state for this cycle
  node_t                      eff_cur;
  logic [htbd_pkg::IDX_W-1:0] eff_walk;
  logic [htbd_pkg::IDX_W-1:0] child;

  logic                   push;
  logic [htbd_pkg::SYM_W-1:0] push_data;
  logic [OCW-1:0]         out_count;
  logic                   in_accept;
  logic                   cfg_accept;

  assign wr_entry = '{leaf:  node_is_leaf,
                      sym:   SYMBOL_BITS'(node_symbol),
                      left:  left_child,
                      right: right_child};

  assign rd_entry = p_oob ? '0 : node_t'(ram_rdata);

  assign cfg_ready  = (rf_state == htbd_pkg::RF_IDLE);
  assign cfg_accept = cfg_valid && cfg_ready;
  // Worst case one symbol per cycle still in flight; leave room for it.
  assign in_ready   = (rf_state == htbd_pkg::RF_IDLE) &&
                      ((3'(out_count) + 3'(p_read) + 3'(p_emit)) < 3'(OUT_DEPTH));
  assign in_accept  = in_valid && in_ready;

  assign child = code_bit ? eff_cur.right : eff_cur.left;

  // Resolve the pending child read or the pending leaf emit
  always_comb begin
    push      = 1'b0;
    push_data = htbd_pkg::SYM_W'(p_sym);
    eff_cur   = cur_entry;
    eff_walk  = walk;
    if (p_read) begin
      if (rd_entry.leaf) begin
        push      = 1'b1;
        push_data = htbd_pkg::SYM_W'(rd_entry.sym);
        eff_cur   = root_entry;
        eff_walk  = root;
      end else begin
        eff_cur = rd_entry;
      end
    end else if (p_emit) begin
      push = 1'b1;
    end
  end

  always_comb begin
    walk_next       = eff_walk;
    cur_entry_next  = eff_cur;
    root_entry_next = root_entry;
    p_read_next     = 1'b0;
    p_oob_next      = p_oob;
    p_emit_next     = 1'b0;
    p_sym_next      = p_sym;
    rf_state_next   = rf_state;
    ram_we          = 1'b0;
    ram_waddr       = AW'(node_index);
    ram_re          = 1'b0;
    ram_raddr       = AW'(child);

    if (in_accept) begin
      unique case (htbd_pkg::mode_t'(mode))
        htbd_pkg::MODE_WRITE: begin
          if (in_range(node_index)) begin
            ram_we = 1'b1;
            // keep cached entries coherent with the table
            if (node_index == eff_walk) begin
              cur_entry_next = wr_entry;
            end
            if (node_index == root) begin
              root_entry_next = wr_entry;
            end
          end
        end
        htbd_pkg::MODE_BIT: begin
          if (eff_cur.leaf) begin
            p_emit_next    = 1'b1;
            p_sym_next     = eff_cur.sym;
            cur_entry_next = root_entry;
            walk_next      = root;
          end else begin
            ram_re      = 1'b1;
            p_read_next = 1'b1;
            p_oob_next  = !in_range(child);
            walk_next   = child;
          end
        end
        htbd_pkg::MODE_RESTART: begin
          cur_entry_next = root_entry;
          walk_next      = root;
        end
        default: begin
        end
      endcase
    end

    unique case (rf_state)
      htbd_pkg::RF_IDLE: begin
        if (cfg_accept) begin
          rf_state_next = htbd_pkg::RF_READ;
        end
      end
      htbd_pkg::RF_READ: begin
        ram_re        = 1'b1;
        ram_raddr     = AW'(root);
        rf_state_next = htbd_pkg::RF_WAIT;
      end
      htbd_pkg::RF_WAIT: begin
        root_entry_next = rf_oob ? '0 : node_t'(ram_rdata);
        rf_state_next   = htbd_pkg::RF_IDLE;
      end
      default: begin
        rf_state_next = htbd_pkg::RF_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root     <= '0;
      walk     <= '0;
      p_read   <= 1'b0;
      p_emit   <= 1'b0;
      rf_state <= htbd_pkg::RF_IDLE;
    end else begin
      if (cfg_accept) begin
        root <= root_index;
      end
      walk     <= walk_next;
      p_read   <= p_read_next;
      p_emit   <= p_emit_next;
      rf_state <= rf_state_next;
    end
  end

  always_ff @(posedge clk) begin
    root_entry <= root_entry_next;
    cur_entry  <= cur_entry_next;
    p_oob      <= p_oob_next;
    p_sym      <= p_sym_next;
    if (rf_state == htbd_pkg::RF_READ) begin
      rf_oob <= !in_range(root);
    end
  end

  htbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  htbd_fifo #(
    .WIDTH (htbd_pkg::SYM_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (symbol),
    .count     (out_count)
  );

endmodule

FILE: tb/tb_huffman_tree_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_bit_decoder
// Self-checking bench for the tree-walk decoder. The low part of the node
// table is filled first; every walk stays on written entries. A directed
// sequence covers leaf roots, restarts, the unused mode, table and root
// changes under the walk. Random trees are then built, loaded and decoded
// from their code words under three idle settings, and a long output
// hold-off fills the block.
// A local table model predicts every symbol, checked in order at the output.
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder;

  localparam int NODES         = 512;
  localparam int USED_NODES    = 64;   // random trees live in this range
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [htbd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [htbd_pkg::IDX_W-1:0]  root_index   = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [htbd_pkg::MODE_W-1:0] mode         = MODE_UNUSED;
  logic [htbd_pkg::IDX_W-1:0]  node_index   = '0;
  logic                        node_is_leaf = 1'b0;
  logic [htbd_pkg::SYM_W-1:0]  node_symbol  = '0;
  logic [htbd_pkg::IDX_W-1:0]  left_child   = '0;
  logic [htbd_pkg::IDX_W-1:0]  right_child  = '0;
  logic                        code_bit     = 1'b0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [htbd_pkg::SYM_W-1:0]  symbol;

  // bench-side copy of the decoder state
  logic                       tab_leaf  [NODES];
  logic [htbd_pkg::SYM_W-1:0] tab_sym   [NODES];
  logic [htbd_pkg::IDX_W-1:0] tab_left  [NODES];
  logic [htbd_pkg::IDX_W-1:0] tab_right [NODES];
  logic [htbd_pkg::IDX_W-1:0] walk_pos  = '0;
  logic [htbd_pkg::IDX_W-1:0] root_reg  = '0;
  logic [htbd_pkg::SYM_W-1:0] pending_symbols[$];
  logic [htbd_pkg::SYM_W-1:0] exp_sym;

  int  tx_idle_pct  = 0;
  int  rx_idle_pct  = 0;
  logic rx_hold     = 1'b0;
  int  n_fail       = 0;
  int  n_sent       = 0;
  int  stall_cycles = 0;
  logic handshake;
  bit  node_taken[NODES];

  huffman_tree_bit_decoder #(
    .NODE_COUNT  (NODES),
    .SYMBOL_BITS (htbd_pkg::SYM_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .root_index   (root_index),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .code_bit     (code_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Applies one accepted request to the local state, queues any symbol.
  function automatic void decode_request();
    logic [htbd_pkg::IDX_W-1:0] nxt;
    case (mode)
      htbd_pkg::MODE_WRITE: begin
        tab_leaf[node_index]  = node_is_leaf;
        tab_sym[node_index]   = node_symbol;
        tab_left[node_index]  = left_child;
        tab_right[node_index] = right_child;
      end
      htbd_pkg::MODE_RESTART: walk_pos = root_reg;
      htbd_pkg::MODE_BIT: begin
        if (tab_leaf[walk_pos]) begin
          // walk parked on a leaf: emit it without stepping
          pending_symbols.push_back(tab_sym[walk_pos]);
          walk_pos = root_reg;
        end else begin
          nxt = code_bit ? tab_right[walk_pos] : tab_left[walk_pos];
          if (tab_leaf[nxt]) begin
            pending_symbols.push_back(tab_sym[nxt]);
            walk_pos = root_reg;
          end else begin
            walk_pos = nxt;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      handshake = 1'b0;
      if (cfg_valid && cfg_ready) begin
        root_reg  = root_index;
        handshake = 1'b1;
      end
      if (in_valid && in_ready) begin
        decode_request();
        handshake = 1'b1;
      end
      if (out_valid && out_ready) begin
        handshake = 1'b1;
        if (pending_symbols.size() == 0) begin
          $error("symbol: no request pending, actual %0d", symbol);
          n_fail++;
        end else begin
          exp_sym = pending_symbols.pop_front();
          if (symbol !== exp_sym) begin
            $error("symbol mismatch: expected %0d, actual %0d", exp_sym, symbol);
            n_fail++;
          end
        end
      end
      stall_cycles = handshake ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_huffman_tree_bit_decoder: FAIL");
    $finish;
  end

  task automatic send_req(input logic [htbd_pkg::MODE_W-1:0] m,
                          input logic [htbd_pkg::IDX_W-1:0] idx,
                          input logic lf, input logic [htbd_pkg::SYM_W-1:0] sy,
                          input logic [htbd_pkg::IDX_W-1:0] lc,
                          input logic [htbd_pkg::IDX_W-1:0] rc,
                          input logic b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    node_index   <= idx;
    node_is_leaf <= lf;
    node_symbol  <= sy;
    left_child   <= lc;
    right_child  <= rc;
    code_bit     <= b;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic write_node(input int idx, input logic lf, input int sy,
                            input int lc, input int rc);
    send_req(htbd_pkg::MODE_WRITE, htbd_pkg::IDX_W'(idx), lf, htbd_pkg::SYM_W'(sy),
             htbd_pkg::IDX_W'(lc), htbd_pkg::IDX_W'(rc), 1'($urandom_range(1)));
  endtask

  task automatic send_bit(input logic b);
    send_req(htbd_pkg::MODE_BIT, htbd_pkg::IDX_W'($urandom_range(NODES - 1)),
             1'($urandom_range(1)), htbd_pkg::SYM_W'($urandom_range(255)),
             htbd_pkg::IDX_W'($urandom_range(NODES - 1)),
             htbd_pkg::IDX_W'($urandom_range(NODES - 1)), b);
  endtask

  task automatic send_op(input logic [htbd_pkg::MODE_W-1:0] m);
    send_req(m, htbd_pkg::IDX_W'($urandom_range(NODES - 1)),
             1'($urandom_range(1)), htbd_pkg::SYM_W'($urandom_range(255)),
             htbd_pkg::IDX_W'($urandom_range(NODES - 1)),
             htbd_pkg::IDX_W'($urandom_range(NODES - 1)), 1'($urandom_range(1)));
  endtask

  // Stop sending, wait for every predicted symbol, then let the pipe settle.
  task automatic wait_for_symbols();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(input int idx);
    cfg_valid  <= 1'b1;
    root_index <= htbd_pkg::IDX_W'(idx);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int claim_node();
    int i;
    do i = $urandom_range(USED_NODES - 1); while (node_taken[i]);
    node_taken[i] = 1'b1;
    return i;
  endfunction

  // Fills the low range with leaves; their random children are never followed.
  task automatic test_fill_table();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < USED_NODES; i++)
      write_node(i, 1'b1, $urandom_range(255), $urandom_range(NODES - 1),
                 $urandom_range(NODES - 1));
    wait_for_symbols();
  endtask

  task automatic test_directed();
    tx_idle_pct = 30;
    rx_idle_pct = 50;
    send_bit(1'b0);                          // reset root 0 holds a leaf
    write_node(NODES - 1, 1'b0, 255, 0, NODES - 2);
    write_node(0, 1'b1, 0, NODES - 1, NODES - 1);
    write_node(NODES - 2, 1'b0, 0, 1, 0);
    write_node(1, 1'b1, 255, 0, 0);
    wait_for_symbols();
    set_root(NODES - 1);
    send_op(MODE_UNUSED);
    send_bit(1'b1);                          // walk still on old root
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_op(htbd_pkg::MODE_RESTART);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b1);                          // now parked on an internal node
    write_node(NODES - 2, 1'b1, 8'hA5, 0, 0);
    send_bit(1'b0);
    write_node(NODES - 2, 1'b0, 0, 1, 0);
    send_bit(1'b1);
    wait_for_symbols();
    set_root(0);                             // walk stays where it was
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    wait_for_symbols();
  endtask

  task automatic run_tree();
    int k;
    int n_slots;
    int n_leaves;
    int s;
    int c;
    int m;
    int nsym;
    int slot_node[32];
    int slot_left[32];
    int slot_right[32];
    bit slot_leaf[32];
    logic [15:0] slot_code[32];
    int slot_len[32];
    foreach (node_taken[i]) node_taken[i] = 1'b0;
    k = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
    slot_node[0] = claim_node();
    slot_leaf[0] = 1'b1;
    slot_code[0] = 16'($urandom);
    slot_len[0]  = 0;
    n_slots      = 1;
    n_leaves     = 1;
    // grow a random full binary tree by splitting leaves
    while (n_leaves < k) begin
      do s = $urandom_range(n_slots - 1); while (!slot_leaf[s]);
      for (int j = 0; j < 2; j++) begin
        c = n_slots + j;
        slot_node[c] = claim_node();
        slot_leaf[c] = 1'b1;
        slot_code[c] = slot_code[s];
        slot_code[c][slot_len[s]] = (j == 1);
        slot_len[c] = slot_len[s] + 1;
      end
      slot_left[s]  = n_slots;
      slot_right[s] = n_slots + 1;
      slot_leaf[s]  = 1'b0;
      n_slots += 2;
      n_leaves++;
    end
    for (int i = 0; i < n_slots; i++) begin
      if (slot_leaf[i])
        write_node(slot_node[i], 1'b1, $urandom_range(255), $urandom_range(NODES - 1),
                   $urandom_range(NODES - 1));
      else
        write_node(slot_node[i], 1'b0, $urandom_range(255), slot_node[slot_left[i]],
                   slot_node[slot_right[i]]);
    end
    wait_for_symbols();
    set_root(slot_node[0]);
    if ($urandom_range(3) != 0) send_op(htbd_pkg::MODE_RESTART);
    nsym = $urandom_range(16, 6);
    repeat (nsym) begin
      do s = $urandom_range(n_slots - 1); while (!slot_leaf[s]);
      m = (slot_len[s] == 0) ? 1 : slot_len[s];
      for (int b = 0; b < m; b++) begin
        if ($urandom_range(99) < 6) begin
          case ($urandom_range(2))
            0:       send_op(MODE_UNUSED);
            1:       send_op(htbd_pkg::MODE_RESTART);
            default: write_node($urandom_range(USED_NODES - 1), 1'($urandom_range(1)),
                                $urandom_range(255), $urandom_range(USED_NODES - 1),
                                $urandom_range(USED_NODES - 1));
          endcase
        end
        send_bit(slot_code[s][b]);
      end
      if ($urandom_range(9) == 0) wait_for_symbols();
    end
  endtask

  task automatic test_random_trees(input int tx_pct, input int rx_pct, input int n_items);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = n_sent;
    while (n_sent - start < n_items) run_tree();
    wait_for_symbols();
  endtask

  // Leaf root: every bit yields a symbol while the output is held off.
  task automatic test_backpressure();
    int leaf_idx;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    leaf_idx = $urandom_range(USED_NODES - 1);
    write_node(leaf_idx, 1'b1, $urandom_range(255), $urandom_range(NODES - 1),
               $urandom_range(NODES - 1));
    wait_for_symbols();
    set_root(leaf_idx);
    send_op(htbd_pkg::MODE_RESTART);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (100) send_bit(1'($urandom_range(1)));
    join
    wait_for_symbols();
  endtask

  initial begin
    foreach (tab_leaf[i]) begin
      tab_leaf[i]  = 1'b0;
      tab_sym[i]   = '0;
      tab_left[i]  = '0;
      tab_right[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_random_trees(30, 82, 130);
    test_random_trees(82, 30, 130);
    test_random_trees(0, 0, 130);
    test_backpressure();
    if (n_fail == 0 && pending_symbols.size() == 0)
      $display("tb_huffman_tree_bit_decoder: PASS");
    else
      $display("tb_huffman_tree_bit_decoder: FAIL");
    $finish;
  end

endmodule

FILE: huffman_tree_bit_decoder.f
hw/rtl/htbd_pkg.sv
hw/rtl/htbd_ram.sv
hw/rtl/htbd_fifo.sv
hw/rtl/huffman_tree_bit_decoder.sv
tb/tb_huffman_tree_bit_decoder.sv
